### hw/rtl/flfa_pkg.sv
package flfa_pkg;

	localparam int unsigned PRESS_W = 18;
	localparam int unsigned HEIGHT_W = 16;

	localparam logic [1:0] REQ_PACKET = 2'd0;
	localparam logic [1:0] REQ_MISS = 2'd1;
	localparam logic [1:0] REQ_LOCK_CHECK = 2'd2;

	localparam logic [7:0] LOCK_ARM = 8'd1;
	localparam logic [7:0] LOCK_DISARM = 8'd2;
	localparam logic [7:0] MODE_HOVER = 8'd2;
	localparam logic [7:0] TRIM_INC = 8'h01;
	localparam logic [7:0] TRIM_DEC = 8'hFF;
	localparam logic [7:0] TOGGLE_CODE = 8'h55;

	localparam logic CFG_TILT_LIMIT = 1'b0;
	localparam logic CFG_LINK_LOSS_LIMIT = 1'b1;
	localparam logic [7:0] TILT_LIMIT_RST = 8'd50;
	localparam logic [7:0] LINK_LOSS_LIMIT_RST = 8'd50;

	// ceil(2^26 / 10): exact quotient by ten for dividends below 2^22
	localparam int unsigned DIV10_SHIFT = 26;
	localparam logic [22:0] DIV10_MUL = 23'd6710887;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] trim_x_cmd;
		logic [7:0] trim_y_cmd;
		logic [7:0] mode_cmd;
		logic [7:0] lock_cmd;
		logic [7:0] toggle_cmd;
		logic signed [8:0] angle_x;
		logic signed [8:0] angle_y;
		logic [PRESS_W-1:0] press_filt;
		logic [PRESS_W-1:0] press_inst;
	} req_t;

	typedef struct packed {
		logic armed;
		logic link_ok;
		logic [7:0] flight_mode;
		logic signed [HEIGHT_W-1:0] height;
		logic signed [HEIGHT_W-1:0] hover_target;
		logic signed [15:0] trim_x;
		logic signed [15:0] trim_y;
		logic save_request;
		logic toggle_bit;
		logic motors_stop;
	} res_t;

endpackage

### hw/rtl/flfa_height.sv
module flfa_height (
	input  logic [flfa_pkg::PRESS_W-1:0]         ref_press,
	input  logic [flfa_pkg::PRESS_W-1:0]         press,
	output logic signed [flfa_pkg::HEIGHT_W-1:0] height
);
	import flfa_pkg::*;

	logic signed [PRESS_W:0] diff;
	logic                    neg;
	logic [PRESS_W-1:0]      mag;
	logic [PRESS_W+3:0]      scaled;
	logic [PRESS_W+26:0]     prod;
	logic [PRESS_W-1:0]      quot;

	assign diff = $signed({1'b0, ref_press}) - $signed({1'b0, press});
	assign neg = diff[PRESS_W];
	assign mag = neg ? PRESS_W'(-diff) : diff[PRESS_W-1:0];
	assign scaled = {1'b0, mag, 3'b000} + {4'b0000, mag};
	assign prod = {23'd0, scaled} * {22'd0, DIV10_MUL};
	assign quot = prod[DIV10_SHIFT+PRESS_W-1:DIV10_SHIFT];

	always_comb begin
		if (neg) begin
			if (quot > PRESS_W'(32768))
				height = 16'sh8000;
			else
				height = HEIGHT_W'(-$signed({1'b0, quot}));
		end else begin
			if (quot > PRESS_W'(32767))
				height = 16'sh7FFF;
			else
				height = quot[HEIGHT_W-1:0];
		end
	end

endmodule

### hw/rtl/flfa_state.sv
module flfa_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  flfa_pkg::req_t  req,
	input  logic [7:0]      tilt_limit,
	input  logic [7:0]      link_loss_limit,
	output flfa_pkg::res_t  res
);
	import flfa_pkg::*;

	logic                       armed_q, armed_n;
	logic                       link_q, link_n;
	logic [7:0]                 miss_q, miss_n;
	logic [7:0]                 mode_q, mode_n;
	logic [PRESS_W-1:0]         ref_q, ref_n;
	logic signed [HEIGHT_W-1:0] height_q, height_n;
	logic signed [HEIGHT_W-1:0] height_now_q, height_now_n;
	logic signed [HEIGHT_W-1:0] hover_q, hover_n;
	logic [15:0]                trim_x_q, trim_x_n;
	logic [15:0]                trim_y_q, trim_y_n;
	logic                       save_q, save_n;
	logic                       toggle_q, toggle_n;
	logic                       stop;

	logic signed [HEIGHT_W-1:0] h_press;
	logic signed [HEIGHT_W-1:0] h_press_now;
	logic signed [9:0]          ax, ay, lim;
	logic                       tilt_bad;
	logic [8:0]                 miss_inc;

	flfa_height u_height (
		.ref_press(ref_q),
		.press    (req.press_filt),
		.height   (h_press)
	);

	flfa_height u_height_now (
		.ref_press(ref_q),
		.press    (req.press_inst),
		.height   (h_press_now)
	);

	assign ax = {req.angle_x[8], req.angle_x};
	assign ay = {req.angle_y[8], req.angle_y};
	assign lim = $signed({2'b00, tilt_limit});
	assign tilt_bad = (ax > lim) || (ax < -lim) || (ay > lim) || (ay < -lim);
	assign miss_inc = {1'b0, miss_q} + 9'd1;

	always_comb begin
		armed_n = armed_q;
		link_n = link_q;
		miss_n = miss_q;
		mode_n = mode_q;
		ref_n = ref_q;
		height_n = height_q;
		height_now_n = height_now_q;
		hover_n = hover_q;
		trim_x_n = trim_x_q;
		trim_y_n = trim_y_q;
		save_n = save_q;
		toggle_n = toggle_q;
		stop = 1'b0;
		case (req.req_type)
			REQ_PACKET: begin
				if (req.trim_x_cmd == TRIM_INC) begin
					trim_x_n = trim_x_q + 16'd1;
					save_n = 1'b1;
				end else if (req.trim_x_cmd == TRIM_DEC) begin
					trim_x_n = trim_x_q - 16'd1;
					save_n = 1'b1;
				end
				if (req.trim_y_cmd == TRIM_INC) begin
					trim_y_n = trim_y_q + 16'd1;
					save_n = 1'b1;
				end else if (req.trim_y_cmd == TRIM_DEC) begin
					trim_y_n = trim_y_q - 16'd1;
					save_n = 1'b1;
				end
				if (req.mode_cmd == MODE_HOVER && mode_q != MODE_HOVER)
					hover_n = height_now_q;
				mode_n = req.mode_cmd;
				if (req.lock_cmd == LOCK_ARM && !armed_q) begin
					ref_n = req.press_filt;
					height_n = '0;
					armed_n = 1'b1;
				end
				if (req.lock_cmd == LOCK_DISARM)
					armed_n = 1'b0;
				if (req.toggle_cmd == TOGGLE_CODE)
					toggle_n = !toggle_q;
				link_n = 1'b1;
				miss_n = '0;
			end
			REQ_MISS: begin
				if (miss_inc >= {1'b0, link_loss_limit}) begin
					miss_n = link_loss_limit;
					link_n = 1'b0;
				end else begin
					miss_n = miss_inc[7:0];
				end
			end
			REQ_LOCK_CHECK: begin
				armed_n = armed_q && link_q && !tilt_bad;
				if (!armed_n) begin
					stop = 1'b1;
					height_n = '0;
					mode_n = '0;
				end else begin
					height_n = h_press;
					height_now_n = h_press_now;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			link_q <= 1'b0;
			miss_q <= '0;
			mode_q <= '0;
			ref_q <= '0;
			height_q <= '0;
			height_now_q <= '0;
			hover_q <= '0;
			trim_x_q <= '0;
			trim_y_q <= '0;
			save_q <= 1'b0;
			toggle_q <= 1'b0;
		end else if (en) begin
			armed_q <= armed_n;
			link_q <= link_n;
			miss_q <= miss_n;
			mode_q <= mode_n;
			ref_q <= ref_n;
			height_q <= height_n;
			height_now_q <= height_now_n;
			hover_q <= hover_n;
			trim_x_q <= trim_x_n;
			trim_y_q <= trim_y_n;
			save_q <= save_n;
			toggle_q <= toggle_n;
		end
	end

	always_comb begin
		res.armed = armed_n;
		res.link_ok = link_n;
		res.flight_mode = mode_n;
		res.height = height_n;
		res.hover_target = hover_n;
		res.trim_x = trim_x_n;
		res.trim_y = trim_y_n;
		res.save_request = save_n;
		res.toggle_bit = toggle_n;
		res.motors_stop = stop;
	end

endmodule

### hw/rtl/flight_link_failsafe_arming_top.sv
// Flight link, failsafe and arming controller.
// Request channel (req_valid / req_stall): one event per transaction, a
// received packet, a missing packet or a lock check, with its payload fields.
// Response channel (rsp_valid / rsp_stall): one transaction per request with
// the arming, link, mode, height, trim and flag state after that event.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 writes
// tilt_limit, index 1 writes link_loss_limit; write only while idle.
// An accepted request passes through the input register, then the result
// register, before it appears on the response channel. Throughput: one
// request per cycle while the receiver does not stall; the whole event
// update is one pass of logic, whose longest path is the pressure-to-height
// multiply by 9/10. When the receiver stalls, the result holds in the
// response register, the next request still enters the input register, and
// only then does req_stall rise. Reset clears all flight state, both limits
// return to 50, and both channels come up empty.
module flight_link_failsafe_arming_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [1:0]                           req_type,
	input  logic [7:0]                           trim_x_cmd,
	input  logic [7:0]                           trim_y_cmd,
	input  logic [7:0]                           mode_cmd,
	input  logic [7:0]                           lock_cmd,
	input  logic [7:0]                           toggle_cmd,
	input  logic signed [8:0]                    angle_x,
	input  logic signed [8:0]                    angle_y,
	input  logic [flfa_pkg::PRESS_W-1:0]         press_filt,
	input  logic [flfa_pkg::PRESS_W-1:0]         press_inst,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic                                 armed,
	output logic                                 link_ok,
	output logic [7:0]                           flight_mode,
	output logic signed [flfa_pkg::HEIGHT_W-1:0] height,
	output logic signed [flfa_pkg::HEIGHT_W-1:0] hover_target,
	output logic signed [15:0]                   trim_x,
	output logic signed [15:0]                   trim_y,
	output logic                                 save_request,
	output logic                                 toggle_bit,
	output logic                                 motors_stop,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [7:0]                           cfg_data
);
	import flfa_pkg::*;

	logic       valid_s1;
	req_t       req_s1;
	logic       advance;
	logic       accept;
	res_t       res;
	res_t       res_q;
	logic       rsp_valid_q;
	logic [7:0] tilt_limit_q;
	logic [7:0] link_loss_limit_q;

	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_limit_q <= TILT_LIMIT_RST;
			link_loss_limit_q <= LINK_LOSS_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TILT_LIMIT: tilt_limit_q <= cfg_data;
				CFG_LINK_LOSS_LIMIT: link_loss_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type <= req_type;
			req_s1.trim_x_cmd <= trim_x_cmd;
			req_s1.trim_y_cmd <= trim_y_cmd;
			req_s1.mode_cmd <= mode_cmd;
			req_s1.lock_cmd <= lock_cmd;
			req_s1.toggle_cmd <= toggle_cmd;
			req_s1.angle_x <= angle_x;
			req_s1.angle_y <= angle_y;
			req_s1.press_filt <= press_filt;
			req_s1.press_inst <= press_inst;
		end
	end

	flfa_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.req            (req_s1),
		.tilt_limit     (tilt_limit_q),
		.link_loss_limit(link_loss_limit_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= advance || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign armed = res_q.armed;
	assign link_ok = res_q.link_ok;
	assign flight_mode = res_q.flight_mode;
	assign height = res_q.height;
	assign hover_target = res_q.hover_target;
	assign trim_x = res_q.trim_x;
	assign trim_y = res_q.trim_y;
	assign save_request = res_q.save_request;
	assign toggle_bit = res_q.toggle_bit;
	assign motors_stop = res_q.motors_stop;

endmodule

### hw/rtl/flfa_checker.sv
module flfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              armed,
	input logic [7:0]        flight_mode,
	input logic signed [15:0] height,
	input logic signed [15:0] trim_x,
	input logic              save_request,
	input logic              motors_stop
);

	a_stop_means_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && motors_stop |-> !armed && flight_mode == 8'd0 && height == 16'sd0)
		else $error("motors stopped while armed or with live height/mode");

	a_arm_zero_height: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && $rose(armed) |-> height == 16'sd0)
		else $error("arming transaction shows nonzero height");

	a_save_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(rsp_valid) && rsp_valid |-> !$fell(save_request))
		else $error("save request cleared");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		$past(req_valid && !req_stall) && rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken with both stages full");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(trim_x) && $stable(armed))
		else $error("stalled response changed");

endmodule

bind flight_link_failsafe_arming_top flfa_checker u_flfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.armed       (armed),
	.flight_mode (flight_mode),
	.height      (height),
	.trim_x      (trim_x),
	.save_request(save_request),
	.motors_stop (motors_stop)
);

### tb/tb.sv
import flfa_pkg::*;

class flight_state_tracker;
	logic [7:0] tilt_lim;
	logic [7:0] loss_lim;
	bit armed_q;
	bit link_q;
	bit save_q;
	bit toggle_q;
	logic [7:0] misses;
	logic [7:0] mode_q;
	logic [PRESS_W-1:0] ref_press;
	logic signed [15:0] height_q;
	logic signed [15:0] height_now_q;
	logic signed [15:0] hover_q;
	logic signed [15:0] trim_x_q;
	logic signed [15:0] trim_y_q;
	res_t status_due[$];
	int unsigned errors;
	int unsigned seen;

	function new();
		tilt_lim = TILT_LIMIT_RST;
		loss_lim = LINK_LOSS_LIMIT_RST;
		armed_q = 1'b0;
		link_q = 1'b0;
		save_q = 1'b0;
		toggle_q = 1'b0;
		misses = '0;
		mode_q = '0;
		ref_press = '0;
		height_q = '0;
		height_now_q = '0;
		hover_q = '0;
		trim_x_q = '0;
		trim_y_q = '0;
		errors = 0;
		seen = 0;
	endfunction

	function void set_limit(logic idx, logic [7:0] v);
		if (idx == CFG_TILT_LIMIT)
			tilt_lim = v;
		else
			loss_lim = v;
	endfunction

	function logic signed [15:0] height_from(logic [PRESS_W-1:0] p);
		int d;
		d = (int'(ref_press) - int'(p)) * 9 / 10;
		if (d > 32767)
			d = 32767;
		if (d < -32768)
			d = -32768;
		return d[15:0];
	endfunction

	function logic signed [15:0] step_trim(logic signed [15:0] t, logic [7:0] c);
		if (c == TRIM_INC) begin
			save_q = 1'b1;
			return t + 16'sd1;
		end
		if (c == TRIM_DEC) begin
			save_q = 1'b1;
			return t - 16'sd1;
		end
		return t;
	endfunction

	function void apply_event(req_t r);
		res_t e;
		bit stop;
		int lim;
		int ax;
		int ay;
		logic [8:0] count;
		stop = 1'b0;
		lim = int'(tilt_lim);
		ax = $signed(r.angle_x);
		ay = $signed(r.angle_y);
		case (r.req_type)
		REQ_PACKET: begin
			trim_x_q = step_trim(trim_x_q, r.trim_x_cmd);
			trim_y_q = step_trim(trim_y_q, r.trim_y_cmd);
			if (r.mode_cmd == MODE_HOVER && mode_q != MODE_HOVER)
				hover_q = height_now_q;
			mode_q = r.mode_cmd;
			if (r.lock_cmd == LOCK_ARM && !armed_q) begin
				ref_press = r.press_filt;
				height_q = '0;
				armed_q = 1'b1;
			end
			if (r.lock_cmd == LOCK_DISARM)
				armed_q = 1'b0;
			if (r.toggle_cmd == TOGGLE_CODE)
				toggle_q = !toggle_q;
			link_q = 1'b1;
			misses = '0;
		end
		REQ_MISS: begin
			count = {1'b0, misses} + 9'd1;
			if (count >= {1'b0, loss_lim}) begin
				misses = loss_lim;
				link_q = 1'b0;
			end else begin
				misses = count[7:0];
			end
		end
		REQ_LOCK_CHECK: begin
			if (!link_q)
				armed_q = 1'b0;
			if (ax < -lim || ax > lim || ay < -lim || ay > lim)
				armed_q = 1'b0;
			if (!armed_q) begin
				stop = 1'b1;
				height_q = '0;
				mode_q = '0;
			end else begin
				height_q = height_from(r.press_filt);
				height_now_q = height_from(r.press_inst);
			end
		end
		default: ;
		endcase
		e.armed = armed_q;
		e.link_ok = link_q;
		e.flight_mode = mode_q;
		e.height = height_q;
		e.hover_target = hover_q;
		e.trim_x = trim_x_q;
		e.trim_y = trim_y_q;
		e.save_request = save_q;
		e.toggle_bit = toggle_q;
		e.motors_stop = stop;
		status_due.push_back(e);
	endfunction

	task flag_mismatch(string what);
		if (errors < 100)
			$display("mismatch at result %0d: %s", seen, what);
		errors++;
	endtask

	task check_field(string name, int got, int want);
		if (got != want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task compare_status(res_t got);
		res_t want;
		if (status_due.size() == 0) begin
			flag_mismatch("result with nothing expected");
			return;
		end
		want = status_due.pop_front();
		check_field("armed", got.armed, want.armed);
		check_field("link_ok", got.link_ok, want.link_ok);
		check_field("flight_mode", got.flight_mode, want.flight_mode);
		check_field("height", got.height, want.height);
		check_field("hover_target", got.hover_target, want.hover_target);
		check_field("trim_x", got.trim_x, want.trim_x);
		check_field("trim_y", got.trim_y, want.trim_y);
		check_field("save_request", got.save_request, want.save_request);
		check_field("toggle_bit", got.toggle_bit, want.toggle_bit);
		check_field("motors_stop", got.motors_stop, want.motors_stop);
		seen++;
	endtask
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [7:0] MODE_MANUAL = 8'd0;
	localparam logic [7:0] MODE_AUTO = 8'd1;
	localparam logic [7:0] LOCK_NONE = 8'd0;
	localparam logic [7:0] TRIM_HOLD = 8'd0;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_CYCLES = 80;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = '0;
	logic [7:0] trim_x_cmd = '0;
	logic [7:0] trim_y_cmd = '0;
	logic [7:0] mode_cmd = '0;
	logic [7:0] lock_cmd = '0;
	logic [7:0] toggle_cmd = '0;
	logic signed [8:0] angle_x = '0;
	logic signed [8:0] angle_y = '0;
	logic [PRESS_W-1:0] press_filt = '0;
	logic [PRESS_W-1:0] press_inst = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic armed;
	logic link_ok;
	logic [7:0] flight_mode;
	logic signed [HEIGHT_W-1:0] height;
	logic signed [HEIGHT_W-1:0] hover_target;
	logic signed [15:0] trim_x;
	logic signed [15:0] trim_y;
	logic save_request;
	logic toggle_bit;
	logic motors_stop;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int press_base = 100000;
	flight_state_tracker tracker = new();

	flight_link_failsafe_arming_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		res_t got;
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				got.armed = armed;
				got.link_ok = link_ok;
				got.flight_mode = flight_mode;
				got.height = height;
				got.hover_target = hover_target;
				got.trim_x = trim_x;
				got.trim_y = trim_y;
				got.save_request = save_request;
				got.toggle_bit = toggle_bit;
				got.motors_stop = motors_stop;
				tracker.compare_status(got);
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
			end
		end
	end

	task automatic send_item(req_t it);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 99) < 34) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= it.req_type;
		trim_x_cmd <= it.trim_x_cmd;
		trim_y_cmd <= it.trim_y_cmd;
		mode_cmd <= it.mode_cmd;
		lock_cmd <= it.lock_cmd;
		toggle_cmd <= it.toggle_cmd;
		angle_x <= it.angle_x;
		angle_y <= it.angle_y;
		press_filt <= it.press_filt;
		press_inst <= it.press_inst;
		do @(posedge clk); while (req_stall);
		tracker.apply_event(it);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (tracker.status_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic req_t packet_event(logic [7:0] tx, logic [7:0] ty, logic [7:0] mode,
			logic [7:0] lock, logic [7:0] tog, logic [PRESS_W-1:0] p);
		req_t e;
		e = '0;
		e.req_type = REQ_PACKET;
		e.trim_x_cmd = tx;
		e.trim_y_cmd = ty;
		e.mode_cmd = mode;
		e.lock_cmd = lock;
		e.toggle_cmd = tog;
		e.press_filt = p;
		return e;
	endfunction

	function automatic req_t check_event(int ax, int ay, logic [PRESS_W-1:0] p,
			logic [PRESS_W-1:0] pn);
		req_t e;
		e = '0;
		e.req_type = REQ_LOCK_CHECK;
		e.angle_x = ax[8:0];
		e.angle_y = ay[8:0];
		e.press_filt = p;
		e.press_inst = pn;
		return e;
	endfunction

	function automatic logic signed [8:0] pick_angle();
		int lim;
		int a;
		lim = (tracker.tilt_lim > 8'd180) ? 180 : int'(tracker.tilt_lim);
		if ($urandom_range(0, 99) < 75)
			a = int'($urandom_range(0, 2 * lim)) - lim;
		else
			a = int'($urandom_range(0, 360)) - 180;
		return a[8:0];
	endfunction

	function automatic logic [PRESS_W-1:0] pick_press();
		int p;
		if ($urandom_range(0, 99) < 15) begin
			p = $urandom_range(0, 262143);
		end else begin
			p = press_base + int'($urandom_range(0, 80000)) - 40000;
			if (p < 0)
				p = 0;
			if (p > 262143)
				p = 262143;
		end
		return p[PRESS_W-1:0];
	endfunction

	function automatic req_t random_event(logic [1:0] kind);
		req_t e;
		e = {$urandom, $urandom, $urandom};
		e.req_type = kind;
		e.angle_x = pick_angle();
		e.angle_y = pick_angle();
		e.press_filt = pick_press();
		e.press_inst = pick_press();
		if (kind == REQ_PACKET) begin
			case ($urandom_range(0, 2))
			0: e.trim_x_cmd = TRIM_INC;
			1: e.trim_x_cmd = TRIM_DEC;
			default: ;
			endcase
			case ($urandom_range(0, 2))
			0: e.trim_y_cmd = TRIM_INC;
			1: e.trim_y_cmd = TRIM_DEC;
			default: ;
			endcase
			if ($urandom_range(0, 99) < 75)
				e.mode_cmd = 8'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
			0, 1, 2: e.lock_cmd = LOCK_ARM;
			3: e.lock_cmd = LOCK_DISARM;
			default: ;
			endcase
			if ($urandom_range(0, 99) < 30)
				e.toggle_cmd = TOGGLE_CODE;
		end
		return e;
	endfunction

	task automatic run_phase(int unsigned n, logic [7:0] tilt, logic [7:0] loss,
			int unsigned lead, bit quiet, bit hold);
		int unsigned sent;
		int unsigned burst;
		int unsigned roll;
		bit held;
		logic [1:0] kind;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TILT_LIMIT;
		cfg_data <= tilt;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_limit(CFG_TILT_LIMIT, tilt);
		cfg_index <= CFG_LINK_LOSS_LIMIT;
		cfg_data <= loss;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_limit(CFG_LINK_LOSS_LIMIT, loss);
		cfg_valid <= 1'b0;
		calm = quiet;
		press_base = $urandom_range(0, 262143);
		sent = 0;
		held = 1'b0;
		// drive the miss count toward its limit with lead miss events before mixing events
		repeat (lead) begin
			send_item(random_event(REQ_MISS));
			sent++;
		end
		while (sent < n) begin
			if (hold && !held && sent >= n / 2) begin
				hold_request = 1'b1;
				held = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				burst = (tracker.loss_lim > 8'd20) ? $urandom_range(1, 20) :
					$urandom_range(1, tracker.loss_lim + 2);
				repeat (burst) begin
					send_item(random_event(REQ_MISS));
					sent++;
				end
			end else begin
				kind = (roll < 50) ? REQ_PACKET : (roll < 66) ? REQ_MISS :
					(roll < 97) ? REQ_LOCK_CHECK : REQ_UNKNOWN;
				send_item(random_event(kind));
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(check_event(0, 0, 0, 0));
		send_item(packet_event(TRIM_INC, TRIM_DEC, MODE_MANUAL, LOCK_ARM, TOGGLE_CODE, 100000));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_AUTO, LOCK_ARM, 8'h00, 50000));
		send_item(check_event(0, 0, 90000, 0));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_HOVER, LOCK_NONE, 8'h00, 0));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_HOVER, LOCK_NONE, 8'h00, 0));
		send_item(check_event(50, -50, 262143, 100001));
		send_item(check_event(-50, 50, 100011, 99989));
		send_item(packet_event(TRIM_DEC, TRIM_INC, 8'd255, 8'd3, 8'hAA, 262143));
		send_item(packet_event(8'hFE, 8'h02, MODE_HOVER, LOCK_NONE, TOGGLE_CODE, 0));
		send_item(check_event(0, 0, 0, 262143));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_AUTO, LOCK_DISARM, 8'h00, 0));
		send_item(check_event(0, 0, 5, 5));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_AUTO, LOCK_ARM, 8'h00, 0));
		send_item(check_event(51, 0, 0, 0));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_AUTO, LOCK_ARM, 8'h00, 262143));
		send_item(check_event(0, -51, 0, 262143));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_AUTO, LOCK_ARM, 8'h00, 131072));
		send_item(check_event(180, 0, 0, 0));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_AUTO, LOCK_ARM, 8'hFF, 131072));
		send_item(check_event(0, -180, 0, 0));
		send_item(packet_event(TRIM_HOLD, TRIM_HOLD, MODE_HOVER, LOCK_ARM, 8'h00, 131072));
		send_item(check_event(0, 0, 262143, 0));
		send_item(random_event(REQ_UNKNOWN));
		send_item(random_event(REQ_MISS));

		run_phase(160, 8'd0, 8'd1, 0, 1'b0, 1'b0);
		run_phase(320, 8'd180, 8'd255, 257, 1'b0, 1'b1);
		run_phase(200, 8'($urandom_range(20, 90)), 8'($urandom_range(2, 12)), 0, 1'b1, 1'b0);
		run_phase(100, 8'($urandom_range(1, 179)), 8'd0, 0, 1'b0, 1'b1);
		run_phase(250, 8'($urandom_range(30, 70)), 8'($urandom_range(3, 30)), 5, 1'b0, 1'b0);

		drain();
		repeat (6) @(posedge clk);
		if (tracker.status_due.size() != 0)
			tracker.flag_mismatch("results still outstanding at end");
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### sim.f
hw/rtl/flfa_pkg.sv
hw/rtl/flfa_height.sv
hw/rtl/flfa_state.sv
hw/rtl/flight_link_failsafe_arming_top.sv
hw/rtl/flfa_checker.sv
tb/tb.sv
